>>> hw/rtl/fpdf_pkg.sv
// Shared types and constants of the fixed-point decimal formatter.
package fpdf_pkg;

   localparam int MAX_DIGITS  = 39;
   localparam int AMOUNT_W    = 128;
   localparam int BCD_W       = 4 * MAX_DIGITS;
   localparam int PTR_W       = $clog2(MAX_DIGITS);
   localparam int BIT_CNT_W   = $clog2(AMOUNT_W);
   localparam int SCALE_W     = 6;
   localparam int CHAR_W      = 6;

   localparam logic [CHAR_W-1:0]    CH_ZERO   = CHAR_W'(48);
   localparam logic [CHAR_W-1:0]    CH_POINT  = CHAR_W'(46);
   localparam logic [PTR_W-1:0]     LAST_PTR  = PTR_W'(MAX_DIGITS - 1);
   localparam logic [SCALE_W-1:0]   MAX_SCALE = SCALE_W'(MAX_DIGITS - 1);
   localparam logic [BIT_CNT_W-1:0] LAST_BIT  = BIT_CNT_W'(AMOUNT_W - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SCAN,
      ST_PREP,
      ST_EMIT_INT,
      ST_EMIT_POINT,
      ST_EMIT_FRAC
   } fpdf_state_type;

   typedef struct packed {
      logic load;
      logic conv;
      logic scan;
      logic start_emit;
      logic put_digit;
      logic put_point;
      logic last;
   } fpdf_cmd_type;

   typedef struct packed {
      logic scan_done;
      logic at_scale;
      logic has_frac;
      logic frac_end;
      logic out_free;
   } fpdf_status_type;

endpackage

>>> hw/rtl/fpdf_datapath.sv
// Datapath: double-dabble converter, digit scan, emission pointer and result register.
module fpdf_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  fpdf_pkg::fpdf_cmd_type                cmd,
   output fpdf_pkg::fpdf_status_type             status,
   input  logic                                  csr_valid,
   input  logic [fpdf_pkg::SCALE_W-1:0]          csr_unit_scale,
   input  logic [63:0]                           req_amount_high,
   input  logic [63:0]                           req_amount_low,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [fpdf_pkg::CHAR_W-1:0]           rsp_text_char,
   output logic                                  rsp_last_char
);
   import fpdf_pkg::*;

   logic [SCALE_W-1:0]  unit_scale_ff;
   logic [AMOUNT_W-1:0] bin_ff;
   logic [BCD_W-1:0]    bcd_ff;
   logic [BCD_W-1:0]    bcd_adj;
   logic [PTR_W-1:0]    ptr_ff;
   logic [PTR_W-1:0]    top_ff;
   logic [PTR_W-1:0]    low_frac_ff;
   logic                rsp_valid_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic                last_ff;
   logic [PTR_W-1:0]    scale;
   logic [3:0]          dig_sel;
   logic                dig_nz;

   assign scale   = (unit_scale_ff > MAX_SCALE) ? PTR_W'(MAX_SCALE) : PTR_W'(unit_scale_ff);
   assign dig_sel = bcd_ff[{ptr_ff, 2'b00} +: 4];
   assign dig_nz  = (dig_sel != 4'd0);

   // add three to every digit of five or more before the shift
   always_comb begin
      for (int d = 0; d < MAX_DIGITS; d++) begin
         bcd_adj[d*4 +: 4] = (bcd_ff[d*4 +: 4] >= 4'd5) ? bcd_ff[d*4 +: 4] + 4'd3
                                                         : bcd_ff[d*4 +: 4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_scale_ff <= '0;
      end else if (csr_valid) begin
         unit_scale_ff <= csr_unit_scale;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         bin_ff      <= {req_amount_high, req_amount_low};
         bcd_ff      <= '0;
         ptr_ff      <= '0;
         top_ff      <= '0;
         low_frac_ff <= scale;
      end else if (cmd.conv) begin
         bcd_ff <= {bcd_adj[BCD_W-2:0], bin_ff[AMOUNT_W-1]};
         bin_ff <= {bin_ff[AMOUNT_W-2:0], 1'b0};
      end else if (cmd.scan) begin
         if (dig_nz) begin
            top_ff <= ptr_ff;
         end
         // keep only the lowest nonzero fractional digit
         if (dig_nz && (ptr_ff < scale) && (low_frac_ff == scale)) begin
            low_frac_ff <= ptr_ff;
         end
         ptr_ff <= ptr_ff + PTR_W'(1);
      end else if (cmd.start_emit) begin
         ptr_ff <= (top_ff > scale) ? top_ff : scale;
      end else if (cmd.put_digit) begin
         ptr_ff <= ptr_ff - PTR_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.put_digit || cmd.put_point) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.put_digit) begin
         char_ff <= CH_ZERO + CHAR_W'(dig_sel);
         last_ff <= cmd.last;
      end else if (cmd.put_point) begin
         char_ff <= CH_POINT;
         last_ff <= 1'b0;
      end
   end

   assign status.scan_done = (ptr_ff == LAST_PTR);
   assign status.at_scale  = (ptr_ff == scale);
   assign status.has_frac  = (low_frac_ff != scale);
   assign status.frac_end  = (ptr_ff == low_frac_ff);
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_text_char = char_ff;
   assign rsp_last_char = last_ff;

endmodule

>>> hw/rtl/fpdf_ctrl.sv
// Controller: sequences conversion, digit scan and character emission.
module fpdf_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  fpdf_pkg::fpdf_status_type  status,
   output fpdf_pkg::fpdf_cmd_type     cmd
);
   import fpdf_pkg::*;

   fpdf_state_type       state_ff;
   fpdf_state_type       state_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff;
   logic [BIT_CNT_W-1:0] bit_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load   = 1'b1;
               bit_cnt_in = '0;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            cmd.conv   = 1'b1;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == LAST_BIT) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_done) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.start_emit = 1'b1;
            state_in       = ST_EMIT_INT;
         end
         ST_EMIT_INT: begin
            if (status.out_free) begin
               cmd.put_digit = 1'b1;
               cmd.last      = status.at_scale && !status.has_frac;
               if (status.at_scale) begin
                  state_in = status.has_frac ? ST_EMIT_POINT : ST_IDLE;
               end
            end
         end
         ST_EMIT_POINT: begin
            if (status.out_free) begin
               cmd.put_point = 1'b1;
               state_in      = ST_EMIT_FRAC;
            end
         end
         ST_EMIT_FRAC: begin
            if (status.out_free) begin
               cmd.put_digit = 1'b1;
               cmd.last      = status.frac_end;
               if (status.frac_end) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/fixed_point_decimal_formatter_core.sv
// Top level of the fixed-point decimal formatter.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_amount_high, req_amount_low
//   rsp      out        rsp_valid/rsp_stall  rsp_text_char, rsp_last_char
//   csr      in         csr_valid/csr_ready  csr_unit_scale
//
// An item passes an accept state, a double-dabble shift over all 128 amount bits,
// a scan of all 39 digits, a setup state and one character per cycle while the
// result side does not stall. The shift loop and the single-pointer digit scan dominate.
// The next item is accepted once the last character enters the output register.
// Reset clears the controller, the output valid and unit_scale to zero.
// A stall on rsp holds the output register and pauses emission.
module fixed_point_decimal_formatter_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [63:0]                      req_amount_high,
   input  logic [63:0]                      req_amount_low,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [fpdf_pkg::CHAR_W-1:0]      rsp_text_char,
   output logic                             rsp_last_char,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [fpdf_pkg::SCALE_W-1:0]     csr_unit_scale
);
   import fpdf_pkg::*;

   fpdf_cmd_type    cmd;
   fpdf_status_type status;

   assign csr_ready = 1'b1;

   fpdf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fpdf_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_valid       (csr_valid && csr_ready),
      .csr_unit_scale  (csr_unit_scale),
      .req_amount_high (req_amount_high),
      .req_amount_low  (req_amount_low),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_text_char   (rsp_text_char),
      .rsp_last_char   (rsp_last_char)
   );

endmodule

>>> hw/rtl/fpdf_checker.sv
// Port-level checker for the formatter core and its bind.
module fpdf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic [fpdf_pkg::CHAR_W-1:0]  rsp_text_char,
   input logic                         rsp_last_char
);
   import fpdf_pkg::*;

   // a stalled item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_text_char)
                                 && $stable(rsp_last_char))
      else $error("rsp item changed under stall");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("req accepted while still converting");

   a_char_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_text_char == CH_POINT
                    || (rsp_text_char >= CH_ZERO && rsp_text_char <= CH_ZERO + CHAR_W'(9)))
      else $error("rsp character out of range");

   a_point_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_text_char == CH_POINT |-> !rsp_last_char)
      else $error("point flagged as last character");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid && !req_stall)
      else $error("not idle after reset");

endmodule

bind fixed_point_decimal_formatter_core fpdf_checker u_fpdf_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_stall     (req_stall),
   .rsp_valid     (rsp_valid),
   .rsp_stall     (rsp_stall),
   .rsp_text_char (rsp_text_char),
   .rsp_last_char (rsp_last_char)
);
